FILE: rtl/core/voice_allocator_with_stealing_unit_macros.svh
// Assertion macros used by the checker file of the voice allocator.
`ifndef VOICE_ALLOCATOR_WITH_STEALING_UNIT_MACROS_SVH
`define VOICE_ALLOCATOR_WITH_STEALING_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A trigger that must be followed by a consequence in the next cycle.
`define VA_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/va_pkg.sv
package va_pkg;

    // Store size and field widths.
    localparam int MAX_VOICES_DEF = 24;
    localparam int COUNT_W        = 5;
    localparam int INDEX_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int LEVEL_W        = 15;
    localparam int AGE_W          = 16;
    localparam int PRIO_W         = 15;
    localparam int OUTCOME_W      = 2;

    localparam logic [COUNT_W-1:0] VOICE_COUNT_RST = 5'd24;

    // Request types.
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    // Voice status codes.
    localparam logic [STATUS_W-1:0] STATUS_IDLE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOISE = 2'd2;

    // Allocation outcomes.
    localparam logic [OUTCOME_W-1:0] OUTCOME_FREE   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_STOLEN = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_NONE   = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_FINISH
    } t_state;

    // Entry of the status and level store.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
    } t_sl_entry;

    // Entry of the age and priority store.
    typedef struct packed {
        logic [AGE_W-1:0]  age;
        logic [PRIO_W-1:0] prio;
    } t_ap_entry;

endpackage

FILE: rtl/core/va_req_if.sv
interface va_req_if;
    import va_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [PRIO_W-1:0]   request_priority;
    logic [INDEX_W-1:0]  voice_index;
    logic [STATUS_W-1:0] voice_status_in;
    logic [LEVEL_W-1:0]  envelope_level;

    modport source (
        output valid, req_type, request_priority, voice_index, voice_status_in,
               envelope_level,
        input  ready
    );

    modport sink (
        input  valid, req_type, request_priority, voice_index, voice_status_in,
               envelope_level,
        output ready
    );

endinterface

FILE: rtl/core/va_rsp_if.sv
interface va_rsp_if;
    import va_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INDEX_W-1:0]   chosen_voice;
    logic [OUTCOME_W-1:0] outcome;
    logic                 noise_release;

    modport source (
        output valid, chosen_voice, outcome, noise_release,
        input  ready
    );

    modport sink (
        input  valid, chosen_voice, outcome, noise_release,
        output ready
    );

endinterface

FILE: rtl/core/va_ram.sv
module va_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/voice_allocator_with_stealing_unit.sv
// Voice allocator with stealing. An update item writes one voice's status and envelope
// level and gives no result. An allocate item walks the first n voices (n is the voice
// count register, capped at MAX_VOICES) one voice per cycle through a shared compare
// unit, stopping early at the first free voice; if a voice was chosen, it then walks the
// same n voices again to age them and to claim the chosen one. The pace of both walks
// is set by the single read port of each voice store. The input is not ready until
// that work is done, and a finished result waits in an output register while the next
// item may already be taken; a result that is not taken holds the block back. After
// reset all voice stores read as zero at once; no clearing pass is needed.
module voice_allocator_with_stealing_unit #(
    parameter int MAX_VOICES = va_pkg::MAX_VOICES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [va_pkg::COUNT_W-1:0] i_cfg_wdata,
    va_req_if.sink                     i_req,
    va_rsp_if.source                   o_rsp
);
    import va_pkg::*;

    localparam int IW = $clog2(MAX_VOICES);
    localparam int CW = $clog2(MAX_VOICES + 1);

    // Control and working registers.
    t_state                   r_state, n_state;
    logic [COUNT_W-1:0]       r_count;
    logic [CW-1:0]            r_n, n_n;
    logic [PRIO_W-1:0]        r_prio, n_prio;
    logic [CW-1:0]            r_rd_idx, n_rd_idx;
    logic                     r_pend, n_pend;
    logic [IW-1:0]            r_pend_idx, n_pend_idx;
    logic [PRIO_W-1:0]        r_limit, n_limit;
    logic [LEVEL_W:0]         r_best_level, n_best_level;
    logic signed [AGE_W:0]    r_best_age, n_best_age;
    logic                     r_have_cand, n_have_cand;
    logic [IW-1:0]            r_cand, n_cand;
    logic                     r_cand_noise, n_cand_noise;
    logic [IW-1:0]            r_chosen, n_chosen;
    logic [OUTCOME_W-1:0]     r_outcome, n_outcome;
    logic                     r_noise, n_noise;
    logic                     r_out_valid, n_out_valid;
    logic [INDEX_W-1:0]       r_out_voice, n_out_voice;
    logic [OUTCOME_W-1:0]     r_out_outcome, n_out_outcome;
    logic                     r_out_noise, n_out_noise;
    logic [MAX_VOICES-1:0]    r_sl_vld, n_sl_vld;
    logic [MAX_VOICES-1:0]    r_ap_vld, n_ap_vld;
    logic                     r_sl_rvld;
    logic                     r_ap_rvld;

    // Store ports.
    logic                     sl_we;
    logic [IW-1:0]            sl_waddr;
    t_sl_entry                sl_wdata;
    t_sl_entry                sl_rdata;
    logic                     ap_we;
    t_ap_entry                ap_wdata;
    t_ap_entry                ap_rdata;
    logic [IW-1:0]            rd_addr;

    // Combinational helpers.
    t_sl_entry                sl_q;
    t_ap_entry                ap_q;
    logic [CW-1:0]            n_eff;
    logic                     issue;
    logic                     is_free;
    logic                     is_last;
    logic signed [AGE_W:0]    age_s;
    logic signed [AGE_W:0]    age_u;
    logic [LEVEL_W:0]         level_x;
    logic                     c_have;
    logic [PRIO_W-1:0]        c_limit;
    logic [LEVEL_W:0]         c_level;
    logic signed [AGE_W:0]    c_age;
    logic [IW-1:0]            c_cand;
    logic                     c_noise;
    logic                     req_fire;

    // Status and level store, written by update items.
    va_ram #(
        .WIDTH ($bits(t_sl_entry)),
        .DEPTH (MAX_VOICES)
    ) u_sl_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr (sl_waddr),
        .i_wdata (sl_wdata),
        .i_raddr (rd_addr),
        .o_rdata (sl_rdata)
    );

    // Age and priority store, written by the aging pass.
    va_ram #(
        .WIDTH ($bits(t_ap_entry)),
        .DEPTH (MAX_VOICES)
    ) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (ap_we),
        .i_waddr (r_pend_idx),
        .i_wdata (ap_wdata),
        .i_raddr (rd_addr),
        .o_rdata (ap_rdata)
    );

    // Effective voice count, saturated to the store size.
    always_comb begin
        if (32'(r_count) > MAX_VOICES) begin
            n_eff = CW'(MAX_VOICES);
        end else begin
            n_eff = CW'(r_count);
        end
    end

    // Read side: an entry never written reads as zero.
    assign rd_addr  = r_rd_idx[IW-1:0];
    assign issue    = ((r_state == ST_SCAN) || (r_state == ST_AGE)) && (r_rd_idx < r_n);
    assign sl_q     = r_sl_rvld ? sl_rdata : '0;
    assign ap_q     = r_ap_rvld ? ap_rdata : '0;
    assign is_free  = (sl_q.status == STATUS_IDLE) && (sl_q.level == '0);
    assign is_last  = ((CW'(r_pend_idx) + CW'(1)) == r_n);
    assign age_s    = {ap_q.age[AGE_W-1], ap_q.age};
    assign age_u    = {1'b0, ap_q.age};
    assign level_x  = {1'b0, sl_q.level};
    assign req_fire = i_req.valid && i_req.ready;

    // Update item writes land in the status and level store.
    assign sl_we          = req_fire && (i_req.req_type == REQ_UPDATE)
                            && (32'(i_req.voice_index) < MAX_VOICES);
    assign sl_waddr       = IW'(i_req.voice_index);
    assign sl_wdata.status = i_req.voice_status_in;
    assign sl_wdata.level  = i_req.envelope_level;

    // Aging pass: each of the first n voices ages, the chosen one restarts with the new priority.
    assign ap_we = (r_state == ST_AGE) && r_pend;
    always_comb begin
        if (r_pend_idx == r_chosen) begin
            ap_wdata.age  = '0;
            ap_wdata.prio = r_prio;
        end else begin
            ap_wdata.age  = ap_q.age + AGE_W'(1);
            ap_wdata.prio = ap_q.prio;
        end
    end

    // Shared compare unit: priority first, then level, then signed age.
    always_comb begin
        c_have  = r_have_cand;
        c_limit = r_limit;
        c_level = r_best_level;
        c_age   = r_best_age;
        c_cand  = r_cand;
        c_noise = r_cand_noise;
        if (ap_q.prio < r_limit) begin
            c_have  = 1'b1;
            c_limit = ap_q.prio;
            c_level = level_x;
            c_age   = age_u;
            c_cand  = r_pend_idx;
            c_noise = (sl_q.status == STATUS_NOISE);
        end else if (ap_q.prio == r_limit) begin
            c_have = 1'b1;
            if (level_x < r_best_level) begin
                c_level = level_x;
                c_age   = age_u;
                c_cand  = r_pend_idx;
                c_noise = (sl_q.status == STATUS_NOISE);
            end else if (level_x == r_best_level) begin
                if (r_best_age < age_s) begin
                    c_age   = age_s;
                    c_cand  = r_pend_idx;
                    c_noise = (sl_q.status == STATUS_NOISE);
                end
            end
        end
    end

    // Sequencer: next state and next register values.
    always_comb begin
        n_state       = r_state;
        n_n           = r_n;
        n_prio        = r_prio;
        n_rd_idx      = r_rd_idx;
        n_pend        = 1'b0;
        n_pend_idx    = r_pend_idx;
        n_limit       = r_limit;
        n_best_level  = r_best_level;
        n_best_age    = r_best_age;
        n_have_cand   = r_have_cand;
        n_cand        = r_cand;
        n_cand_noise  = r_cand_noise;
        n_chosen      = r_chosen;
        n_outcome     = r_outcome;
        n_noise       = r_noise;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_voice   = r_out_voice;
        n_out_outcome = r_out_outcome;
        n_out_noise   = r_out_noise;
        n_sl_vld      = r_sl_vld;
        n_ap_vld      = r_ap_vld;

        if (sl_we) begin
            n_sl_vld[sl_waddr] = 1'b1;
        end
        if (ap_we) begin
            n_ap_vld[r_pend_idx] = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire && (i_req.req_type == REQ_ALLOC)) begin
                    n_n          = n_eff;
                    n_prio       = i_req.request_priority;
                    n_rd_idx     = '0;
                    n_limit      = i_req.request_priority;
                    n_best_level = '1;
                    n_best_age   = '0;
                    n_have_cand  = 1'b0;
                    n_cand       = '0;
                    n_cand_noise = 1'b0;
                    n_chosen     = '0;
                    n_outcome    = OUTCOME_NONE;
                    n_noise      = 1'b0;
                    if (n_eff == '0) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_pend     = issue;
                n_pend_idx = rd_addr;
                n_rd_idx   = r_rd_idx + CW'(issue);
                if (r_pend) begin
                    n_limit      = c_limit;
                    n_best_level = c_level;
                    n_best_age   = c_age;
                    n_have_cand  = c_have;
                    n_cand       = c_cand;
                    n_cand_noise = c_noise;
                    if (is_free) begin
                        n_chosen  = r_pend_idx;
                        n_outcome = OUTCOME_FREE;
                        n_noise   = 1'b0;
                        n_state   = ST_AGE;
                        n_rd_idx  = '0;
                        n_pend    = 1'b0;
                    end else if (is_last) begin
                        n_rd_idx = '0;
                        n_pend   = 1'b0;
                        if (c_have) begin
                            n_chosen  = c_cand;
                            n_outcome = OUTCOME_STOLEN;
                            n_noise   = c_noise;
                            n_state   = ST_AGE;
                        end else begin
                            n_chosen  = '0;
                            n_outcome = OUTCOME_NONE;
                            n_noise   = 1'b0;
                            n_state   = ST_FINISH;
                        end
                    end
                end
            end
            ST_AGE: begin
                n_pend     = issue;
                n_pend_idx = rd_addr;
                n_rd_idx   = r_rd_idx + CW'(issue);
                if (r_pend && is_last) begin
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_voice   = INDEX_W'(r_chosen);
                    n_out_outcome = r_outcome;
                    n_out_noise   = r_noise;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= VOICE_COUNT_RST;
            r_n           <= '0;
            r_prio        <= '0;
            r_rd_idx      <= '0;
            r_pend        <= 1'b0;
            r_pend_idx    <= '0;
            r_limit       <= '0;
            r_best_level  <= '0;
            r_best_age    <= '0;
            r_have_cand   <= 1'b0;
            r_cand        <= '0;
            r_cand_noise  <= 1'b0;
            r_chosen      <= '0;
            r_outcome     <= OUTCOME_NONE;
            r_noise       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out_voice   <= '0;
            r_out_outcome <= OUTCOME_NONE;
            r_out_noise   <= 1'b0;
            r_sl_vld      <= '0;
            r_ap_vld      <= '0;
            r_sl_rvld     <= 1'b0;
            r_ap_rvld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_n           <= n_n;
            r_prio        <= n_prio;
            r_rd_idx      <= n_rd_idx;
            r_pend        <= n_pend;
            r_pend_idx    <= n_pend_idx;
            r_limit       <= n_limit;
            r_best_level  <= n_best_level;
            r_best_age    <= n_best_age;
            r_have_cand   <= n_have_cand;
            r_cand        <= n_cand;
            r_cand_noise  <= n_cand_noise;
            r_chosen      <= n_chosen;
            r_outcome     <= n_outcome;
            r_noise       <= n_noise;
            r_out_valid   <= n_out_valid;
            r_out_voice   <= n_out_voice;
            r_out_outcome <= n_out_outcome;
            r_out_noise   <= n_out_noise;
            r_sl_vld      <= n_sl_vld;
            r_ap_vld      <= n_ap_vld;
            r_sl_rvld     <= r_sl_vld[rd_addr];
            r_ap_rvld     <= r_ap_vld[rd_addr];
        end
    end

    // Channel outputs.
    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.chosen_voice  = r_out_voice;
    assign o_rsp.outcome       = r_out_outcome;
    assign o_rsp.noise_release = r_out_noise;

endmodule

FILE: rtl/core/va_checker.sv
`include "voice_allocator_with_stealing_unit_macros.svh"

module va_checker #(
    parameter int MAX_VOICES = va_pkg::MAX_VOICES_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_req_type,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [va_pkg::INDEX_W-1:0]   i_chosen_voice,
    input logic [va_pkg::OUTCOME_W-1:0] i_outcome,
    input logic                         i_noise_release
);
    import va_pkg::*;

    // A result that is not taken stays on the port unchanged.
    `VA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_chosen_voice) && $stable(i_outcome) && $stable(i_noise_release), "result dropped or changed while stalled")

    // No voice means a zero index and no noise release.
    `VA_ASSERT(a_none_clean, i_clk, i_rst_n, i_rsp_valid && (i_outcome == OUTCOME_NONE) |-> (i_chosen_voice == '0) && !i_noise_release, "empty result carries a voice")

    // A free voice was idle, so it cannot release noise; the chosen voice exists.
    `VA_ASSERT(a_free_voice, i_clk, i_rst_n, i_rsp_valid && (i_outcome == OUTCOME_FREE) |-> !i_noise_release && (32'(i_chosen_voice) < MAX_VOICES), "free voice result is inconsistent")

    // An update item never produces a result.
    `VA_ASSERT_NEXT(a_update_silent, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_type == REQ_UPDATE) && !i_rsp_valid, !i_rsp_valid, "update item produced a result")

    // An allocate item keeps the block busy for at least the next cycle.
    `VA_ASSERT_NEXT(a_alloc_busy, i_clk, i_rst_n, i_req_valid && i_req_ready && (i_req_type == REQ_ALLOC), !i_req_ready, "ready during an allocation")

endmodule

bind voice_allocator_with_stealing_unit va_checker #(
    .MAX_VOICES (MAX_VOICES)
) u_va_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_req_type      (i_req.req_type),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_chosen_voice  (o_rsp.chosen_voice),
    .i_outcome       (o_rsp.outcome),
    .i_noise_release (o_rsp.noise_release)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import va_pkg::*;

    // One request item as the sender sees it.
    typedef struct {
        logic                req_type;
        logic [PRIO_W-1:0]   prio;
        logic [INDEX_W-1:0]  idx;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
    } t_voice_req;

    // One allocation result.
    typedef struct {
        logic [INDEX_W-1:0]   voice;
        logic [OUTCOME_W-1:0] outcome;
        logic                 noise;
    } t_alloc_result;

    // One row of the directed table: either a register write or an item.
    typedef struct {
        bit                 is_cfg;
        logic [COUNT_W-1:0] cfg_val;
        t_voice_req         item;
        bit                 typed;
        t_alloc_result      exp;
    } t_dir_row;

    localparam int SETTLE_CYCLES = 60;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;

    va_req_if req_bus ();
    va_rsp_if rsp_bus ();

    voice_allocator_with_stealing_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // Shadow copy of the voice stores and the voice count register.
    logic [STATUS_W-1:0] bank_status [MAX_VOICES_DEF];
    logic [LEVEL_W-1:0]  bank_level  [MAX_VOICES_DEF];
    logic [AGE_W-1:0]    bank_age    [MAX_VOICES_DEF];
    logic [PRIO_W-1:0]   bank_prio   [MAX_VOICES_DEF];
    logic [COUNT_W-1:0]  scan_count;

    t_alloc_result pending_allocs [$];
    t_dir_row      dir_rows [$];
    int            errors;
    bit            stall_on;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // Watchdog for a hung block.
    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    // Predict one allocate item and advance the shadow state.
    function automatic t_alloc_result pick_voice(input logic [PRIO_W-1:0] prio);
        int                n;
        int                v;
        int                chosen;
        int                cand;
        int                best_level;
        int                best_age;
        int                sa;
        bit                found_free;
        bit                found_cand;
        logic [PRIO_W-1:0] limit;
        t_alloc_result     r;
        n = (scan_count > MAX_VOICES_DEF) ? MAX_VOICES_DEF : int'(scan_count);
        chosen = 0;
        cand = 0;
        best_level = 'hFFFF;
        best_age = 0;
        found_free = 1'b0;
        found_cand = 1'b0;
        limit = prio;
        for (v = 0; v < n; v++) begin
            if (bank_status[v] == STATUS_IDLE && bank_level[v] == '0) begin
                found_free = 1'b1;
                chosen = v;
                break;
            end
            if (bank_prio[v] < limit) begin
                limit = bank_prio[v];
                cand = v;
                best_level = int'(bank_level[v]);
                best_age = int'(bank_age[v]);
                found_cand = 1'b1;
            end else if (bank_prio[v] == limit) begin
                found_cand = 1'b1;
                if (int'(bank_level[v]) < best_level) begin
                    best_level = int'(bank_level[v]);
                    best_age = int'(bank_age[v]);
                    cand = v;
                end else if (int'(bank_level[v]) == best_level) begin
                    // The candidate age is signed while the held best is unsigned.
                    sa = int'($signed(bank_age[v]));
                    if (best_age < sa) begin
                        best_age = sa;
                        cand = v;
                    end
                end
            end
        end
        if (found_free) begin
            r.outcome = OUTCOME_FREE;
        end else if (found_cand) begin
            chosen = cand;
            r.outcome = OUTCOME_STOLEN;
        end else begin
            r.outcome = OUTCOME_NONE;
        end
        r.noise = 1'b0;
        if (r.outcome != OUTCOME_NONE) begin
            for (v = 0; v < n; v++) begin
                bank_age[v] = bank_age[v] + 16'd1;
            end
            bank_age[chosen] = '0;
            bank_prio[chosen] = prio;
            r.noise = (bank_status[chosen] == STATUS_NOISE);
        end else begin
            chosen = 0;
        end
        r.voice = INDEX_W'(chosen);
        return r;
    endfunction

    function automatic t_voice_req mk_req(input logic rt, input int prio, input int idx,
                                          input int st, input int lvl);
        t_voice_req it;
        it.req_type = rt;
        it.prio = PRIO_W'(prio);
        it.idx = INDEX_W'(idx);
        it.status = STATUS_W'(st);
        it.level = LEVEL_W'(lvl);
        return it;
    endfunction

    // Random item; ties in priority and level are made common on purpose.
    function automatic t_voice_req rand_item();
        t_voice_req it;
        int         pick;
        it.prio = PRIO_W'($urandom);
        it.idx = INDEX_W'($urandom);
        it.status = STATUS_W'($urandom);
        it.level = LEVEL_W'($urandom);
        it.req_type = ($urandom_range(0, 99) < 55) ? REQ_UPDATE : REQ_ALLOC;
        if (it.req_type == REQ_UPDATE) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                it.idx = INDEX_W'($urandom_range(MAX_VOICES_DEF, 31));
            end else if (pick < 5) begin
                it.idx = INDEX_W'($urandom_range(0, MAX_VOICES_DEF - 1));
            end else begin
                it.idx = INDEX_W'($urandom_range(0,
                    (scan_count == 0 || scan_count > MAX_VOICES_DEF) ?
                    MAX_VOICES_DEF - 1 : int'(scan_count) - 1));
            end
            pick = $urandom_range(0, 7);
            case (pick)
                0: it.level = '0;
                1: it.level = '1;
                2, 3: it.level = LEVEL_W'($urandom_range(1, 3));
                default: ;
            endcase
        end else begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: it.prio = '0;
                1: it.prio = '1;
                2, 3: it.prio = PRIO_W'($urandom_range(0, 3) * 100);
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic add_row(input bit is_cfg, input int cfg_val, input logic rt,
                           input int prio, input int idx, input int st, input int lvl,
                           input bit typed, input int ev, input logic [OUTCOME_W-1:0] eo,
                           input int en);
        t_dir_row row;
        row.is_cfg = is_cfg;
        row.cfg_val = COUNT_W'(cfg_val);
        row.item = mk_req(rt, prio, idx, st, lvl);
        row.typed = typed;
        row.exp.voice = INDEX_W'(ev);
        row.exp.outcome = eo;
        row.exp.noise = en[0];
        dir_rows.push_back(row);
    endtask

    // Drive one item at the falling edge and hold it until it is accepted.
    task automatic send_item(input t_voice_req it, input bit typed, input t_alloc_result exp);
        int gap;
        gap = (stall_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid = 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid = 1'b1;
        req_bus.req_type = it.req_type;
        req_bus.request_priority = it.prio;
        req_bus.voice_index = it.idx;
        req_bus.voice_status_in = it.status;
        req_bus.envelope_level = it.level;
        do begin
            @(posedge i_clk);
        end while (req_bus.ready !== 1'b1);
        // Accepted at this edge: update the shadow state.
        if (it.req_type == REQ_ALLOC) begin
            t_alloc_result r;
            r = pick_voice(it.prio);
            pending_allocs.push_back(typed ? exp : r);
        end else if (it.idx < MAX_VOICES_DEF) begin
            bank_status[it.idx] = it.status;
            bank_level[it.idx] = it.level;
        end
    endtask

    // Wait until the block is idle, then write the voice count register.
    task automatic write_count(input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (pending_allocs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        scan_count = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        i_cfg_wdata = COUNT_W'($urandom);
    endtask

    // Result side: ready comes and goes in bursts while stalling is enabled.
    initial begin
        rsp_bus.ready = 1'b0;
        forever begin
            if (stall_on && $urandom_range(0, 3) == 0) begin
                @(negedge i_clk);
                rsp_bus.ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                @(negedge i_clk);
                rsp_bus.ready = 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (pending_allocs.size() == 0) begin
                report_mismatch("result item arrived with no allocation outstanding");
            end else begin
                t_alloc_result e;
                e = pending_allocs.pop_front();
                if (rsp_bus.chosen_voice !== e.voice || rsp_bus.outcome !== e.outcome ||
                        rsp_bus.noise_release !== e.noise) begin
                    report_mismatch($sformatf(
                        "voice %0d outcome %0d noise %0d, expected %0d %0d %0d",
                        rsp_bus.chosen_voice, rsp_bus.outcome, rsp_bus.noise_release,
                        e.voice, e.outcome, e.noise));
                end
            end
        end
    end

    // Main stimulus.
    initial begin
        t_alloc_result no_exp;
        int            counts [7];
        int            p;
        int            k;
        errors = 0;
        stall_on = 1'b0;
        no_exp = '{voice: '0, outcome: OUTCOME_NONE, noise: 1'b0};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = REQ_ALLOC;
        req_bus.request_priority = '0;
        req_bus.voice_index = '0;
        req_bus.voice_status_in = '0;
        req_bus.envelope_level = '0;
        for (k = 0; k < MAX_VOICES_DEF; k++) begin
            bank_status[k] = '0;
            bank_level[k] = '0;
            bank_age[k] = '0;
            bank_prio[k] = '0;
        end
        scan_count = VOICE_COUNT_RST;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: cfg, count, type, prio, index, status, level, typed, voice, outcome, noise.
        add_row(0, 0,  REQ_ALLOC,  0,     0,  0, 0,     1, 0, OUTCOME_FREE, 0);
        add_row(0, 0,  REQ_UPDATE, 32767, 0,  2, 32767, 0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  32767, 0,  0, 0,     1, 1, OUTCOME_FREE, 0);
        add_row(0, 0,  REQ_UPDATE, 0,     31, 3, 32767, 0, 0, OUTCOME_NONE, 0);
        add_row(1, 2,  REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_UPDATE, 0,     1,  1, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  0,     31, 3, 32767, 0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(1, 0,  REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  32767, 0,  0, 0,     1, 0, OUTCOME_NONE, 0);
        add_row(1, 31, REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  12345, 0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_UPDATE, 0,     23, 3, 1,     0, 0, OUTCOME_NONE, 0);
        add_row(1, 1,  REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_UPDATE, 0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  32767, 0,  0, 0,     1, 0, OUTCOME_FREE, 0);
        add_row(0, 0,  REQ_UPDATE, 0,     0,  3, 5,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  0,     0,  0, 0,     1, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_ALLOC,  32767, 0,  0, 0,     0, 0, OUTCOME_NONE, 0);
        add_row(0, 0,  REQ_UPDATE, 32767, 24, 2, 32767, 0, 0, OUTCOME_NONE, 0);
        add_row(1, 24, REQ_ALLOC,  0,     0,  0, 0,     0, 0, OUTCOME_NONE, 0);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                write_count(dir_rows[k].cfg_val);
            end else begin
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].exp);
            end
        end

        // Age ties: voices 1 to 3 share priority and level and keep aging while voice 0
        // is taken again and again.
        write_count(COUNT_W'(4));
        send_item(mk_req(REQ_UPDATE, 0, 0, 1, 7), 0, no_exp);
        for (k = 1; k < 4; k++) begin
            send_item(mk_req(REQ_UPDATE, 0, k, 0, 0), 0, no_exp);
        end
        for (k = 1; k < 4; k++) begin
            send_item(mk_req(REQ_ALLOC, 100, 0, 0, 0), 0, no_exp);
            send_item(mk_req(REQ_UPDATE, 0, k, 1, 0), 0, no_exp);
        end
        send_item(mk_req(REQ_UPDATE, 0, 0, 0, 0), 0, no_exp);
        repeat (20) begin
            send_item(mk_req(REQ_ALLOC, $urandom_range(200, 32767), 0, 0, 0), 0, no_exp);
        end
        send_item(mk_req(REQ_UPDATE, 0, 0, 1, 0), 0, no_exp);
        stall_on = 1'b1;
        repeat (4) send_item(mk_req(REQ_ALLOC, 100, 0, 0, 0), 0, no_exp);
        repeat (60) send_item(rand_item(), 0, no_exp);

        // Random phases over several voice counts; the last one runs without stalls.
        counts[0] = 24;
        counts[1] = $urandom_range(1, 23);
        counts[2] = 2;
        counts[3] = 31;
        counts[4] = $urandom_range(1, 23);
        counts[5] = 1;
        counts[6] = 24;
        for (p = 0; p < 7; p++) begin
            write_count(COUNT_W'(counts[p]));
            stall_on = (p == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
            repeat (155) send_item(rand_item(), 0, no_exp);
        end

        // Drain and finish.
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        while (pending_allocs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
